[rtl/lbc_pkg.sv]
package lbc_pkg;

  localparam int NumChannels  = 8;
  localparam int ChanBits     = $clog2(NumChannels);
  localparam int TimeBits     = 32;
  localparam int IntervalBits = 32;
  localparam int CountBits    = 16;

  // Channel operating mode; code 3 is undefined and rejected by set requests
  typedef enum logic [1:0] {
    ModeOff   = 2'd0,
    ModeOn    = 2'd1,
    ModeBlink = 2'd2
  } mode_e;

  // Request type codes
  localparam logic ReqService = 1'b0;
  localparam logic ReqSet     = 1'b1;

  // Per-channel blink record kept in the state RAM
  typedef struct packed {
    logic [TimeBits-1:0]     last_toggle;
    logic [IntervalBits-1:0] toggle_interval;
    logic [CountBits-1:0]    blink_limit;
    logic [CountBits-1:0]    blinks_done;
    logic                    phase_flag;
  } chan_rec_t;

  // One accepted request as handed to the engine
  typedef struct packed {
    logic                    req_type;
    logic [ChanBits-1:0]     led_index;
    logic [1:0]              new_mode;
    logic [CountBits-1:0]    blink_total;
    logic [IntervalBits-1:0] interval;
    logic [TimeBits-1:0]     time_now;
  } lbc_req_t;

  // Engine status toward the top level
  typedef struct packed {
    logic idle;
    logic done;
  } eng_status_t;

endpackage

[rtl/lbc_state_ram.sv]
module lbc_state_ram import lbc_pkg::*; (
  input  logic                clk_i,
  input  logic                we_i,
  input  logic [ChanBits-1:0] waddr_i,
  input  chan_rec_t           wdata_i,
  input  logic                re_i,
  input  logic [ChanBits-1:0] raddr_i,
  output chan_rec_t           rdata_o
);

  chan_rec_t mem [NumChannels];

  // Write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  // Registered read port
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_o <= mem[raddr_i];
    end
  end

endmodule

[rtl/lbc_engine.sv]
module lbc_engine import lbc_pkg::*; (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   start_i,
  input  lbc_req_t               req_i,
  input  logic [NumChannels-1:0] enable_i,
  input  logic [NumChannels-1:0] clr_mask_i,
  input  logic                   take_i,
  output eng_status_t            status_o,
  output logic [NumChannels-1:0] level_o,
  output logic [NumChannels-1:0] blink_o
);

  typedef enum logic [1:0] {
    StIdle,
    StScan,
    StHold
  } state_e;

  state_e                 state_q;
  logic [ChanBits:0]      rd_ptr_q;
  logic                   pv_q;
  logic [ChanBits-1:0]    pidx_q;
  logic [TimeBits-1:0]    now_q;
  mode_e                  mode_q [NumChannels];
  logic [NumChannels-1:0] level_q;

  logic                   ram_we;
  logic [ChanBits-1:0]    ram_waddr;
  chan_rec_t              ram_wdata;
  logic                   ram_re;
  chan_rec_t              ram_rdata;

  logic                   set_go;
  logic                   set_ok;
  logic                   svc_go;
  logic                   rd_more;
  logic                   proc_en;
  logic                   fire;
  logic                   limit_hit;
  logic [TimeBits-1:0]    elapsed;
  logic [CountBits-1:0]   done_inc;
  chan_rec_t              set_rec;
  chan_rec_t              upd_rec;

  lbc_state_ram u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (rd_ptr_q[ChanBits-1:0]),
    .rdata_o (ram_rdata)
  );

  // Decode the incoming request
  always_comb begin
    set_ok = enable_i[req_i.led_index] &&
             (req_i.new_mode == ModeOff || req_i.new_mode == ModeOn ||
              req_i.new_mode == ModeBlink);
    set_go = (state_q == StIdle) && start_i && (req_i.req_type == ReqSet);
    svc_go = (state_q == StIdle) && start_i && (req_i.req_type == ReqService);
  end

  // Service step: compare elapsed time, toggle phase, count blinks; also build the set record
  always_comb begin
    rd_more   = rd_ptr_q < (ChanBits + 1)'(NumChannels);
    ram_re    = (state_q == StScan) && rd_more;
    proc_en   = (state_q == StScan) && pv_q && enable_i[pidx_q] &&
                (mode_q[pidx_q] == ModeBlink);
    elapsed   = now_q - ram_rdata.last_toggle;
    fire      = elapsed >= ram_rdata.toggle_interval;
    done_inc  = ram_rdata.blinks_done + CountBits'(1);
    limit_hit = (ram_rdata.blink_limit != '0) && (done_inc >= ram_rdata.blink_limit);

    upd_rec             = ram_rdata;
    upd_rec.last_toggle = now_q;
    upd_rec.phase_flag  = !ram_rdata.phase_flag;
    if (!ram_rdata.phase_flag && ram_rdata.blink_limit != '0) begin
      upd_rec.blinks_done = done_inc;
    end

    set_rec.last_toggle     = req_i.time_now;
    set_rec.toggle_interval = req_i.interval;
    set_rec.blink_limit     = req_i.blink_total;
    set_rec.blinks_done     = '0;
    set_rec.phase_flag      = 1'b0;
  end

  // Pick the single RAM write: new blink setup or service write-back
  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = pidx_q;
    ram_wdata = upd_rec;
    if (set_go && set_ok && req_i.new_mode == ModeBlink) begin
      ram_we    = 1'b1;
      ram_waddr = req_i.led_index;
      ram_wdata = set_rec;
    end else if (proc_en && fire) begin
      ram_we = 1'b1;
    end
  end

  // Sequencer, read pipeline and per-channel mode and level flags
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= StIdle;
      rd_ptr_q <= '0;
      pv_q     <= 1'b0;
      pidx_q   <= '0;
      now_q    <= '0;
      level_q  <= '0;
      for (int c = 0; c < NumChannels; c++) begin
        mode_q[c] <= ModeOff;
      end
    end else begin
      unique case (state_q)
        StIdle: begin
          if (svc_go) begin
            state_q  <= StScan;
            rd_ptr_q <= '0;
            pv_q     <= 1'b0;
            now_q    <= req_i.time_now;
          end else if (set_go) begin
            state_q <= StHold;
            if (set_ok) begin
              mode_q[req_i.led_index]  <= mode_e'(req_i.new_mode);
              level_q[req_i.led_index] <= (req_i.new_mode != ModeOff);
            end
          end
        end
        StScan: begin
          pv_q   <= rd_more;
          pidx_q <= rd_ptr_q[ChanBits-1:0];
          if (rd_more) begin
            rd_ptr_q <= rd_ptr_q + (ChanBits + 1)'(1);
          end
          if (proc_en && fire) begin
            level_q[pidx_q] <= ram_rdata.phase_flag;
            if (!ram_rdata.phase_flag && limit_hit) begin
              mode_q[pidx_q] <= ModeOff;
            end
          end
          if (!rd_more && pv_q) begin
            state_q <= StHold;
          end
        end
        StHold: begin
          if (take_i) begin
            state_q <= StIdle;
          end
        end
        default: state_q <= StIdle;
      endcase

      // Drop newly enabled channels to off and dark
      for (int c = 0; c < NumChannels; c++) begin
        if (clr_mask_i[c]) begin
          mode_q[c]  <= ModeOff;
          level_q[c] <= 1'b0;
        end
      end
    end
  end

  // Status and masked views of the flags
  always_comb begin
    status_o.idle = (state_q == StIdle);
    status_o.done = (state_q == StHold);
    for (int c = 0; c < NumChannels; c++) begin
      level_o[c] = level_q[c] & enable_i[c];
      blink_o[c] = (mode_q[c] == ModeBlink) & enable_i[c];
    end
  end

endmodule

[rtl/multi_led_blink_controller.sv]
// Eight-channel LED blink controller.
// Request channel (in_valid_i / in_ready_o): req_type_i selects a service
// pass (time_now_i only) or a set of one channel's mode (led_index_i,
// new_mode_i, blink_total_i, interval_i, time_now_i).
// Result channel (out_valid_o / out_ready_i): one result per request with
// led_levels_o and blinking_mask_o as they stand after the request.
// Configuration: cfg_we_i writes cfg_data_i into the channel enable mask;
// a newly enabled channel starts off and dark.
// Flow: a set request goes from acceptance to the hold state and then
// into the output register; a service pass first runs the per-channel
// read-modify-write sweep through the state RAM (one channel per cycle,
// registered read). One request is worked on at a time; the next one
// is accepted at the edge after the result has moved into the output
// register.
// Stall: while out_ready_i is low the result holds in the output register
// and one further finished result waits in the engine, which then does not
// accept a new request.
// Reset: all channels off and dark, enable mask cleared, no result pending.
// The state RAM needs no clearing pass.
module multi_led_blink_controller import lbc_pkg::*; (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    in_valid_i,
  output logic                    in_ready_o,
  input  logic                    req_type_i,
  input  logic [ChanBits-1:0]     led_index_i,
  input  logic [1:0]              new_mode_i,
  input  logic [CountBits-1:0]    blink_total_i,
  input  logic [IntervalBits-1:0] interval_i,
  input  logic [TimeBits-1:0]     time_now_i,
  output logic                    out_valid_o,
  input  logic                    out_ready_i,
  output logic [NumChannels-1:0]  led_levels_o,
  output logic [NumChannels-1:0]  blinking_mask_o,
  input  logic                    cfg_we_i,
  input  logic [NumChannels-1:0]  cfg_data_i
);

  logic [NumChannels-1:0] enable_q;
  logic [NumChannels-1:0] clr_mask;
  logic                   out_valid_q;
  logic [NumChannels-1:0] levels_q;
  logic [NumChannels-1:0] blink_q;
  logic                   take;
  lbc_req_t               req;
  eng_status_t            status;
  logic [NumChannels-1:0] eng_level;
  logic [NumChannels-1:0] eng_blink;

  // Pack the request fields
  always_comb begin
    req.req_type    = req_type_i;
    req.led_index   = led_index_i;
    req.new_mode    = new_mode_i;
    req.blink_total = blink_total_i;
    req.interval    = interval_i;
    req.time_now    = time_now_i;
  end

  assign in_ready_o = status.idle;
  assign clr_mask   = cfg_we_i ? (cfg_data_i & ~enable_q) : '0;
  assign take       = status.done && (!out_valid_q || out_ready_i);

  lbc_engine u_engine (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (in_valid_i),
    .req_i      (req),
    .enable_i   (enable_q),
    .clr_mask_i (clr_mask),
    .take_i     (take),
    .status_o   (status),
    .level_o    (eng_level),
    .blink_o    (eng_blink)
  );

  // Hold the enable mask
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      enable_q <= '0;
    end else if (cfg_we_i) begin
      enable_q <= cfg_data_i;
    end
  end

  // Output register: load a finished result, drop it when taken
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (take) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (take) begin
      levels_q <= eng_level;
      blink_q  <= eng_blink;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign led_levels_o    = levels_q;
  assign blinking_mask_o = blink_q;

`ifndef SYNTHESIS
  // An accepted request keeps the engine busy in the next cycle
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> !in_ready_o)
    else $error("engine idle right after accepting a request");

  // A result is loaded only when the output register is free or draining
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    take |-> !out_valid_q || out_ready_i)
    else $error("result loaded over a pending one");

  // Fresh results never show lit or blinking disabled channels
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    take |=> ((levels_q | blink_q) & ~$past(enable_q)) == '0)
    else $error("disabled channel shown active");
`endif

endmodule

[tb/sv/tb_top.sv]
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import lbc_pkg::*;

  localparam int ClkHalf     = 4;
  localparam int ResetCycles = 9;
  localparam int DrainCycles = 20;
  localparam int StallLimit  = 2000;

  // Mode code that no channel accepts
  localparam logic [1:0] ModeUndef = 2'd3;

  typedef struct packed {
    logic [NumChannels-1:0] levels;
    logic [NumChannels-1:0] blinking;
  } led_view_t;

  // Channel bank model and queue of the LED views still owed by the block
  class led_scoreboard;
    logic [NumChannels-1:0]  enable_mask;
    mode_e                   chan_mode   [NumChannels];
    logic [TimeBits-1:0]     last_toggle [NumChannels];
    logic [IntervalBits-1:0] toggle_ivl  [NumChannels];
    logic [CountBits-1:0]    blink_limit [NumChannels];
    logic [CountBits-1:0]    blinks_done [NumChannels];
    logic                    dark_phase  [NumChannels];
    logic                    lit         [NumChannels];
    led_view_t               view_q [$];
    int                      errors;

    function new();
      enable_mask = '0;
      errors      = 0;
      for (int c = 0; c < NumChannels; c++) clear_channel(c);
    endfunction

    function void clear_channel(int c);
      chan_mode[c]   = ModeOff;
      last_toggle[c] = '0;
      toggle_ivl[c]  = '0;
      blink_limit[c] = '0;
      blinks_done[c] = '0;
      dark_phase[c]  = 1'b0;
      lit[c]         = 1'b0;
    endfunction

    // Reset every channel whose enable bit rises
    function void write_enable(logic [NumChannels-1:0] mask);
      for (int c = 0; c < NumChannels; c++) begin
        if (!enable_mask[c] && mask[c]) clear_channel(c);
      end
      enable_mask = mask;
    endfunction

    // Toggle one blinking channel once its interval has run out
    function void service_channel(int c, logic [TimeBits-1:0] now);
      logic [TimeBits-1:0] elapsed;
      elapsed = now - last_toggle[c];
      if (elapsed < toggle_ivl[c]) return;
      last_toggle[c] = now;
      if (dark_phase[c]) begin
        lit[c]        = 1'b1;
        dark_phase[c] = 1'b0;
        return;
      end
      lit[c]        = 1'b0;
      dark_phase[c] = 1'b1;
      if (blink_limit[c] != '0) begin
        blinks_done[c] = blinks_done[c] + 1'b1;
        if (blinks_done[c] >= blink_limit[c]) chan_mode[c] = ModeOff;
      end
    endfunction

    // Apply one accepted request and queue the LED view it leaves behind
    function void note_request(logic rtype, logic [ChanBits-1:0] idx, logic [1:0] nm,
                               logic [CountBits-1:0] times, logic [IntervalBits-1:0] ivl,
                               logic [TimeBits-1:0] now);
      led_view_t view;
      if (rtype == ReqSet) begin
        if (enable_mask[idx] && (nm == ModeOff || nm == ModeOn || nm == ModeBlink)) begin
          chan_mode[idx]   = mode_e'(nm);
          last_toggle[idx] = now;
          case (mode_e'(nm))
            ModeOff: begin
              lit[idx] = 1'b0;
            end
            ModeOn: begin
              lit[idx] = 1'b1;
            end
            default: begin
              toggle_ivl[idx]  = ivl;
              blink_limit[idx] = times;
              blinks_done[idx] = '0;
              dark_phase[idx]  = 1'b0;
              lit[idx]         = 1'b1;
            end
          endcase
        end
      end else begin
        for (int c = 0; c < NumChannels; c++) begin
          if (enable_mask[c] && chan_mode[c] == ModeBlink) service_channel(c, now);
        end
      end
      view = '0;
      for (int c = 0; c < NumChannels; c++) begin
        if (enable_mask[c]) begin
          view.levels[c]   = lit[c];
          view.blinking[c] = (chan_mode[c] == ModeBlink);
        end
      end
      view_q.push_back(view);
    endfunction

    // Compare one result against the oldest queued view
    function void check_result(logic [NumChannels-1:0] lv, logic [NumChannels-1:0] bm);
      led_view_t want;
      if (view_q.size() == 0) begin
        errors++;
        $display("%0t: result with nothing expected, levels %h mask %h", $time, lv, bm);
        return;
      end
      want = view_q.pop_front();
      if (lv !== want.levels) begin
        errors++;
        $display("%0t: led_levels expected %h actual %h", $time, want.levels, lv);
      end
      if (bm !== want.blinking) begin
        errors++;
        $display("%0t: blinking_mask expected %h actual %h", $time, want.blinking, bm);
      end
    endfunction

    function int pending();
      return view_q.size();
    endfunction
  endclass

  logic                    clk_i = 1'b0;
  logic                    rst_ni;
  logic                    in_valid_i;
  logic                    in_ready_o;
  logic                    req_type_i;
  logic [ChanBits-1:0]     led_index_i;
  logic [1:0]              new_mode_i;
  logic [CountBits-1:0]    blink_total_i;
  logic [IntervalBits-1:0] interval_i;
  logic [TimeBits-1:0]     time_now_i;
  logic                    out_valid_o;
  logic                    out_ready_i = 1'b0;
  logic [NumChannels-1:0]  led_levels_o;
  logic [NumChannels-1:0]  blinking_mask_o;
  logic                    cfg_we_i;
  logic [NumChannels-1:0]  cfg_data_i;

  led_scoreboard       sb;
  logic [TimeBits-1:0] tick;
  bit                  no_gaps = 1'b0;
  int                  stall_left = 0;
  int                  rdy_gap;
  int                  quiet_cycles = 0;

  multi_led_blink_controller u_dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_ready_o     (in_ready_o),
    .req_type_i     (req_type_i),
    .led_index_i    (led_index_i),
    .new_mode_i     (new_mode_i),
    .blink_total_i  (blink_total_i),
    .interval_i     (interval_i),
    .time_now_i     (time_now_i),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .led_levels_o   (led_levels_o),
    .blinking_mask_o(blinking_mask_o),
    .cfg_we_i       (cfg_we_i),
    .cfg_data_i     (cfg_data_i)
  );

  always #(ClkHalf) clk_i = ~clk_i;

  // Mostly short gaps, a few long ones
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (no_gaps || r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  // Stall the result channel at random
  always @(negedge clk_i) begin
    if (stall_left > 0) begin
      out_ready_i = 1'b0;
      stall_left--;
    end else begin
      rdy_gap     = pick_gap();
      out_ready_i = (rdy_gap == 0);
      stall_left  = (rdy_gap > 0) ? rdy_gap - 1 : 0;
    end
  end

  // Observe handshakes and config writes; end the run if traffic stops
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (cfg_we_i) sb.write_enable(cfg_data_i);
      if (in_valid_i && in_ready_o) begin
        sb.note_request(req_type_i, led_index_i, new_mode_i, blink_total_i, interval_i,
                        time_now_i);
      end
      if (out_valid_o && out_ready_i) sb.check_result(led_levels_o, blinking_mask_o);
      if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) begin
        quiet_cycles = 0;
      end else begin
        quiet_cycles++;
      end
      if (quiet_cycles >= StallLimit) begin
        $display("FAIL");
        $finish;
      end
    end
  end

  // Present one request after a random gap and hold it until accepted
  task automatic send_request(input logic rtype, input logic [ChanBits-1:0] idx,
                              input logic [1:0] nm, input logic [CountBits-1:0] times,
                              input logic [IntervalBits-1:0] ivl,
                              input logic [TimeBits-1:0] now);
    int gap;
    gap = pick_gap();
    @(negedge clk_i);
    if (gap > 0) begin
      in_valid_i = 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    req_type_i    = rtype;
    led_index_i   = idx;
    new_mode_i    = nm;
    blink_total_i = times;
    interval_i    = ivl;
    time_now_i    = now;
    in_valid_i    = 1'b1;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
  endtask

  // Drop valid right after the last accepted request
  task automatic end_requests();
    @(negedge clk_i);
    in_valid_i = 1'b0;
  endtask

  task automatic wait_drained();
    while (sb.pending() != 0) @(posedge clk_i);
  endtask

  // Write the enable mask once the block has gone idle
  task automatic apply_enable(input logic [NumChannels-1:0] mask);
    end_requests();
    wait_drained();
    repeat (DrainCycles) @(negedge clk_i);
    cfg_data_i = mask;
    cfg_we_i   = 1'b1;
    @(negedge clk_i);
    cfg_we_i   = 1'b0;
  endtask

  // Mostly mode changes and service passes on an advancing clock, some noise
  task automatic run_random(input int count);
    int                      r;
    int                      m;
    logic [1:0]              nm;
    logic [IntervalBits-1:0] ivl;
    logic [CountBits-1:0]    times;
    repeat (count) begin
      r = $urandom_range(0, 99);
      if (r < 55) begin
        if ($urandom_range(0, 19) == 0) tick = tick + $urandom();
        else tick = tick + $urandom_range(0, 40);
        send_request(ReqService, ChanBits'($urandom()), 2'($urandom()),
                     CountBits'($urandom()), $urandom(), tick);
      end else if (r < 92) begin
        m     = $urandom_range(0, 9);
        nm    = (m < 5) ? ModeBlink : (m < 7) ? ModeOn : (m < 9) ? ModeOff : ModeUndef;
        ivl   = ($urandom_range(0, 9) == 0) ? $urandom() : $urandom_range(0, 60);
        times = ($urandom_range(0, 9) == 0) ? CountBits'($urandom()) :
                                              CountBits'($urandom_range(0, 4));
        send_request(ReqSet, ChanBits'($urandom_range(0, NumChannels - 1)), nm, times,
                     ivl, tick);
      end else begin
        send_request(1'($urandom_range(0, 1)), ChanBits'($urandom()), 2'($urandom()),
                     CountBits'($urandom()), $urandom(), $urandom());
      end
    end
  endtask

  initial begin
    rst_ni        = 1'b0;
    in_valid_i    = 1'b0;
    req_type_i    = ReqService;
    led_index_i   = '0;
    new_mode_i    = ModeOff;
    blink_total_i = '0;
    interval_i    = '0;
    time_now_i    = '0;
    cfg_we_i      = 1'b0;
    cfg_data_i    = '0;
    tick          = 32'hFFFF_FF00;
    sb            = new();
    repeat (ResetCycles) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // Requests while every channel is still disabled
    send_request(ReqSet, 0, ModeBlink, 3, 5, 32'h10);
    send_request(ReqService, '1, ModeUndef, '1, '1, 32'h20);
    apply_enable(8'hFF);

    // One channel per mode, extreme counts and intervals, wrap near the top
    send_request(ReqSet, 0, ModeOn, '1, '1, '0);
    send_request(ReqSet, 1, ModeOff, '1, '1, '1);
    send_request(ReqSet, 2, ModeBlink, 0, 0, 32'h100);
    send_request(ReqSet, 3, ModeBlink, '1, '1, 32'h100);
    send_request(ReqSet, 4, ModeBlink, 1, 10, 32'h100);
    send_request(ReqSet, 5, ModeUndef, 2, 3, 32'h100);
    send_request(ReqSet, 6, ModeBlink, 2, 1, 32'h100);
    send_request(ReqSet, 7, ModeBlink, 2, 100, 32'hFFFF_FFF0);
    send_request(ReqService, 0, ModeOff, 0, 0, 32'h105);
    send_request(ReqService, '1, ModeUndef, '1, '1, 32'h10A);
    send_request(ReqService, 0, ModeOff, 0, 0, 32'h10);
    send_request(ReqService, 0, ModeOff, 0, 0, 32'h60);
    send_request(ReqService, 0, ModeOff, 0, 0, 32'h200);
    send_request(ReqSet, 2, ModeOff, 0, 0, 32'h210);
    send_request(ReqService, 0, ModeOff, 0, 0, 32'h300);
    send_request(ReqService, 0, ModeOff, 0, 0, 32'hFFFF_FFFF);
    send_request(ReqService, 0, ModeOff, 0, 0, 32'h0000_00FF);
    send_request(ReqService, 0, ModeOff, 0, 0, 32'h0000_0400);

    // Random traffic across several enable settings
    apply_enable(8'h00);
    run_random(20);
    apply_enable(8'hA5);
    run_random(80);
    apply_enable(8'h5A);
    no_gaps = 1'b1;
    run_random(60);
    no_gaps = 1'b0;
    run_random(80);

    // Hold off until every result has arrived
    end_requests();
    wait_drained();
    run_random(80);
    apply_enable(NumChannels'($urandom()));
    run_random(80);
    apply_enable(8'h01);
    run_random(40);
    apply_enable(8'h80);
    run_random(40);
    apply_enable(8'hFF);
    run_random(70);

    end_requests();
    wait_drained();
    repeat (DrainCycles) @(posedge clk_i);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule

[filelist.f]
rtl/lbc_pkg.sv
rtl/lbc_state_ram.sv
rtl/lbc_engine.sv
rtl/multi_led_blink_controller.sv
tb/sv/tb_top.sv
